### src/sacl_pkg.sv
package sacl_pkg;

    localparam int NUM_SETS   = 8;
    localparam int NUM_WAYS   = 32;
    localparam int LINE_BYTES = 32;

    localparam int ADDR_W   = 32;
    localparam int TICK_W   = 32;
    localparam int OFFSET_W = $clog2(LINE_BYTES);
    localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int TAG_W    = ADDR_W - OFFSET_W;

    // result field widths on the output stream
    localparam int WAY_FW = 5;
    localparam int SET_FW = 3;
    localparam int OFF_FW = 5;
    localparam int RES_W  = 1 + WAY_FW + SET_FW + OFF_FW + 1 + 2 * ADDR_W;
    localparam int OUT_W  = ((RES_W + 7) / 8) * 8;

    // minimum search: pairwise halving over the ways
    localparam int LEVELS    = $clog2(NUM_WAYS);
    localparam int LVL_CNT_W = $clog2(LEVELS + 1) > 0 ? $clog2(LEVELS + 1) : 1;

    localparam int TAG_ROW_W   = NUM_WAYS * TAG_W;
    localparam int STAMP_ROW_W = NUM_WAYS * TICK_W;

    typedef logic [NUM_WAYS-1:0][TAG_W-1:0]  tag_row_t;
    typedef logic [NUM_WAYS-1:0][TICK_W-1:0] stamp_row_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic             has_free;
        logic [WAY_W-1:0] free_way;
    } lookup_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SEARCH
    } state_t;

    localparam logic ACT_ACCESS     = 1'b0;
    localparam logic ACT_INVALIDATE = 1'b1;

endpackage

### src/sacl_ram.sv
module sacl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/sacl_lookup.sv
module sacl_lookup (
    input  sacl_pkg::tag_row_t                tag_row,
    input  logic [sacl_pkg::NUM_WAYS-1:0]     valid_row,
    input  logic [sacl_pkg::TAG_W-1:0]        tag,
    output sacl_pkg::lookup_t                 result
);
    import sacl_pkg::*;

    // lowest matching way and lowest free way win
    always_comb
    begin
        result = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (valid_row[w] && tag_row[w] == tag)
            begin
                result.hit     = 1'b1;
                result.hit_way = WAY_W'(w);
            end
            if (!valid_row[w])
            begin
                result.has_free = 1'b1;
                result.free_way = WAY_W'(w);
            end
        end
    end

endmodule

### src/sacl_min_search.sv
module sacl_min_search (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  sacl_pkg::stamp_row_t        stamps,
    output logic                        done,
    output logic [sacl_pkg::WAY_W-1:0]  min_way
);
    import sacl_pkg::*;

    logic [TICK_W-1:0]    cand_stamp_reg [NUM_WAYS];
    logic [WAY_W-1:0]     cand_way_reg   [NUM_WAYS];
    logic [LVL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;

    assign done    = busy_reg && (cnt_reg == LVL_CNT_W'(LEVELS));
    assign min_way = cand_way_reg[0];

    // each step halves the candidate list; the lower way wins on ties
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < NUM_WAYS; i++)
            begin
                cand_stamp_reg[i] <= stamps[i];
                cand_way_reg[i]   <= WAY_W'(i);
            end
        end
        else if (busy_reg && !done)
        begin
            for (int i = 0; i < NUM_WAYS / 2; i++)
            begin
                if (cand_stamp_reg[2*i+1] < cand_stamp_reg[2*i])
                begin
                    cand_stamp_reg[i] <= cand_stamp_reg[2*i+1];
                    cand_way_reg[i]   <= cand_way_reg[2*i+1];
                end
                else
                begin
                    cand_stamp_reg[i] <= cand_stamp_reg[2*i];
                    cand_way_reg[i]   <= cand_way_reg[2*i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg && !done)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule

### src/set_assoc_cache_tag_lru_core.sv
// tag and replacement engine of an 8-set, 32-way read cache with 32-byte lines. each
// input transaction carries a byte address in s_tdata and the action in s_tuser: an
// access returns one result transaction (hit, way, set, offset, fill and victim line
// addresses); an invalidate clears every valid bit and the access tick in the cycle it
// is taken and returns nothing. tags and last-use stamps of a set live as one row in two
// simple dual-port synchronous memories, valid bits in flip-flops. an access reads the
// set row when it is taken, then does the tag compare, way choice and row write-back.
// a miss in a full set first runs the halving minimum search over the stamps. one
// access is in flight at a time; a new transaction is taken while the previous result
// still waits in the output register, and a full output register holds the write-back
// back.
module set_assoc_cache_tag_lru_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [sacl_pkg::ADDR_W-1:0] s_tdata,   // address
    input  logic                       s_tuser,   // action
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // hit, way, set_index, byte_offset, evicted_valid, fill_address, victim_address,
    // zero padding
    output logic [sacl_pkg::OUT_W-1:0] m_tdata
);
    import sacl_pkg::*;

    state_t state_reg, state_next;

    logic [NUM_WAYS-1:0] valid_reg [NUM_SETS];
    logic [TICK_W-1:0]   tick_reg;

    // captured access
    logic [SET_W-1:0]    set_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [OFFSET_W-1:0] off_reg;

    // output register
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic                s_acc;
    logic                acc_access;
    logic                acc_inval;
    logic                out_free;

    tag_row_t            tag_rdata;
    stamp_row_t          stamp_rdata;
    tag_row_t            tag_wdata;
    stamp_row_t          stamp_wdata;
    logic [NUM_WAYS-1:0] valid_row;
    lookup_t             lk;

    logic                srch_start;
    logic                srch_done;
    logic [WAY_W-1:0]    srch_way;

    // commit controls from the state machine
    logic                commit;
    logic                commit_hit;
    logic [WAY_W-1:0]    commit_way;
    logic                evicted;
    logic [ADDR_W-1:0]   line_addr;
    logic [ADDR_W-1:0]   fill_addr;
    logic [ADDR_W-1:0]   victim_addr;

    assign s_acc      = s_tvalid && s_tready;
    assign acc_access = s_acc && (s_tuser == ACT_ACCESS);
    assign acc_inval  = s_acc && (s_tuser == ACT_INVALIDATE);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    assign valid_row = valid_reg[set_reg];

    // set-row memories: read at accept, written back at commit
    sacl_ram #(.WIDTH(TAG_ROW_W), .DEPTH(NUM_SETS)) u_tag_ram (
        .clk   (clk),
        .we    (commit),
        .waddr (set_reg),
        .wdata (tag_wdata),
        .re    (acc_access),
        .raddr (s_tdata[OFFSET_W +: SET_W]),
        .rdata (tag_rdata)
    );

    sacl_ram #(.WIDTH(STAMP_ROW_W), .DEPTH(NUM_SETS)) u_stamp_ram (
        .clk   (clk),
        .we    (commit),
        .waddr (set_reg),
        .wdata (stamp_wdata),
        .re    (acc_access),
        .raddr (s_tdata[OFFSET_W +: SET_W]),
        .rdata (stamp_rdata)
    );

    sacl_lookup u_lookup (
        .tag_row   (tag_rdata),
        .valid_row (valid_row),
        .tag       (tag_reg),
        .result    (lk)
    );

    sacl_min_search u_min_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (srch_start),
        .stamps  (stamp_rdata),
        .done    (srch_done),
        .min_way (srch_way)
    );

    // next state and commit decision
    always_comb
    begin
        state_next = state_reg;
        commit     = 1'b0;
        commit_hit = 1'b0;
        commit_way = '0;
        srch_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_access)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (lk.hit || lk.has_free)
                begin
                    commit_hit = lk.hit;
                    commit_way = lk.hit ? lk.hit_way : lk.free_way;
                    if (out_free)
                    begin
                        commit     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // full set: find the oldest stamp
                    srch_start = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                commit_way = srch_way;
                if (srch_done && out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a miss replaces a valid line only when the set was full
    assign evicted     = !commit_hit && valid_row[commit_way];
    assign line_addr   = {tag_reg, OFFSET_W'(0)};
    assign fill_addr   = commit_hit ? '0 : line_addr;
    assign victim_addr = evicted ? {tag_rdata[commit_way], OFFSET_W'(0)} : '0;

    always_comb
    begin
        tag_wdata               = tag_rdata;
        stamp_wdata             = stamp_rdata;
        tag_wdata[commit_way]   = tag_reg;
        stamp_wdata[commit_way] = tick_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            for (int s = 0; s < NUM_SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else if (acc_inval)
        begin
            tick_reg <= '0;
            for (int s = 0; s < NUM_SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else
        begin
            if (acc_access)
            begin
                tick_reg <= tick_reg + 1'b1;
            end
            if (commit)
            begin
                valid_reg[set_reg][commit_way] <= 1'b1;
            end
        end
    end

    // address fields of the access in flight
    always_ff @(posedge clk)
    begin
        if (acc_access)
        begin
            set_reg <= s_tdata[OFFSET_W +: SET_W];
            tag_reg <= s_tdata[ADDR_W-1:OFFSET_W];
            off_reg <= s_tdata[OFFSET_W-1:0];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_tdata_reg <= OUT_W'({victim_addr, fill_addr, evicted, OFF_FW'(off_reg),
                                   SET_FW'(set_reg), WAY_FW'(commit_way), commit_hit});
        end
    end

    // a write-back never overwrites a result that has not been taken
    a_commit_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    // an eviction only happens when every way of the set was valid
    a_evict_full_set: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && evicted) |-> (&valid_row))
        else $error("eviction from a set with a free way");

    // the search is only entered on a miss in a full set
    a_search_on_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
        srch_start |-> (!lk.hit && (&valid_row)))
        else $error("minimum search started needlessly");

    // invalidate leaves the tick at zero and the set in set_reg empty
    a_invalidate_clears: assert property (@(posedge clk) disable iff (!rst_n)
        acc_inval |=> (tick_reg == '0 && valid_reg[set_reg] == '0))
        else $error("invalidate did not clear state");

    // an access is followed by its lookup cycle
    a_access_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        acc_access |=> (state_reg == ST_LOOKUP))
        else $error("access not followed by lookup");

endmodule

### tb/sv/set_assoc_cache_tag_lru_core_tb.sv
`timescale 1ns / 1ps

module set_assoc_cache_tag_lru_core_tb;

    import sacl_pkg::*;

    // cycle limit, far above the slowest correct run of this stimulus
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 75;
    localparam int TAG_HI_W      = ADDR_W - OFFSET_W - SET_W;
    localparam int POOL_MAX      = 48;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 20;

    // one result transaction, hit in the lowest bit as on m_tdata
    typedef struct packed {
        logic [ADDR_W-1:0] victim_address;
        logic [ADDR_W-1:0] fill_address;
        logic              evicted_valid;
        logic [OFF_FW-1:0] byte_offset;
        logic [SET_FW-1:0] set_index;
        logic [WAY_FW-1:0] way;
        logic              hit;
    } lookup_result_t;

    // shadow copy of tags, valid bits and stamps; predicts each lookup
    class lru_tag_scoreboard;
        logic [ADDR_W-1:0] line_tag   [NUM_SETS][NUM_WAYS];
        bit                line_valid [NUM_SETS][NUM_WAYS];
        bit [TICK_W-1:0]   line_stamp [NUM_SETS][NUM_WAYS];
        bit [TICK_W-1:0]   access_tick;
        lookup_result_t    expected_lookups[$];
        int                mismatches;

        function void clear_lines();
            foreach (line_valid[s, w])
            begin
                line_valid[s][w] = 1'b0;
                line_stamp[s][w] = '0;
            end
            access_tick = '0;
        endfunction

        function void note_transaction(logic act, logic [ADDR_W-1:0] addr);
            lookup_result_t    r;
            logic [ADDR_W-1:0] aligned;
            int                off;
            int                set_no;
            int                pick;
            bit                found;
            bit                free_found;
            if (act == ACT_INVALIDATE)
            begin
                clear_lines();
                return;
            end
            access_tick = access_tick + 1;
            off     = addr % LINE_BYTES;
            set_no  = (addr / LINE_BYTES) % NUM_SETS;
            aligned = addr - off;
            found      = 1'b0;
            free_found = 1'b0;
            pick       = 0;
            // matching valid way first
            for (int w = 0; w < NUM_WAYS; w++)
                if (!found && line_valid[set_no][w] && line_tag[set_no][w] == aligned)
                begin
                    found = 1'b1;
                    pick  = w;
                end
            if (!found)
            begin
                // then first invalid way
                for (int w = 0; w < NUM_WAYS; w++)
                    if (!free_found && !line_valid[set_no][w])
                    begin
                        free_found = 1'b1;
                        pick       = w;
                    end
                // then oldest stamp, lowest way on ties
                if (!free_found)
                begin
                    pick = 0;
                    for (int w = 1; w < NUM_WAYS; w++)
                        if (line_stamp[set_no][w] < line_stamp[set_no][pick])
                            pick = w;
                end
            end
            r.hit            = found;
            r.way            = WAY_FW'(pick);
            r.set_index      = SET_FW'(set_no);
            r.byte_offset    = OFF_FW'(off);
            r.evicted_valid  = !found && line_valid[set_no][pick];
            r.fill_address   = found ? '0 : aligned;
            r.victim_address = r.evicted_valid ? line_tag[set_no][pick] : '0;
            line_stamp[set_no][pick] = access_tick;
            line_valid[set_no][pick] = 1'b1;
            line_tag[set_no][pick]   = aligned;
            expected_lookups.push_back(r);
        endfunction

        function void check_lookup(logic [OUT_W-1:0] data);
            lookup_result_t got;
            lookup_result_t want;
            got = lookup_result_t'(data[RES_W-1:0]);
            if (expected_lookups.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %h", data);
                return;
            end
            want = expected_lookups.pop_front();
            if (got.hit !== want.hit || got.way !== want.way
                || got.set_index !== want.set_index
                || got.byte_offset !== want.byte_offset
                || got.evicted_valid !== want.evicted_valid
                || got.fill_address !== want.fill_address
                || got.victim_address !== want.victim_address)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result mismatch");
                    $display("  expected hit %b way %0d set %0d off %0d ev %b fill %h vic %h",
                             want.hit, want.way, want.set_index, want.byte_offset,
                             want.evicted_valid, want.fill_address, want.victim_address);
                    $display("  got      hit %b way %0d set %0d off %0d ev %b fill %h vic %h",
                             got.hit, got.way, got.set_index, got.byte_offset,
                             got.evicted_valid, got.fill_address, got.victim_address);
                end
            end
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [ADDR_W-1:0]  s_tdata;    // address
    logic               s_tuser;    // action
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;    // hit, way, set_index, byte_offset, evicted_valid,
                                    // fill_address, victim_address, zero padding

    lru_tag_scoreboard  sb = new();

    // idling switches per phase, and a one-off long hold-off request
    bit                 sender_idle_on;
    bit                 receiver_idle_on;
    int                 rx_hold_req;
    int                 cycle_count;

    // random tag pool and hot sets of the current phase
    logic [TAG_HI_W-1:0] tag_pool [POOL_MAX];
    int                  pool_size;
    int                  hot_set_base;
    int                  hot_set_span;

    set_assoc_cache_tag_lru_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result monitor: every accepted result transaction goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_lookup(m_tdata);
    end

    // receiver: random stall before each result when idling is on, long hold-off on request
    initial
    begin : receiver
        int wait_cycles;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_req > 0)
            begin
                wait_cycles = rx_hold_req;
                rx_hold_req = 0;
            end
            else
                wait_cycles = receiver_idle_on ? $urandom_range(0, 11) : 0;
            if (wait_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (m_tvalid !== 1'b1) @(posedge clk);
        end
    end

    // offer one transaction and hold it until taken
    task automatic send_item(input logic act, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = sender_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= addr;
        @(posedge clk);
        while (s_tready !== 1'b1) @(posedge clk);
        sb.note_transaction(act, addr);
    endtask

    // sender pause until every outstanding lookup has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic run_directed();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        send_item(ACT_ACCESS, 32'h0000_0000);     // cold miss, way 0
        send_item(ACT_ACCESS, 32'h0000_001F);     // hit, top offset, fill zero
        send_item(ACT_ACCESS, 32'hFFFF_FFFF);     // all ones, last set
        send_item(ACT_ACCESS, 32'hFFFF_FFE0);     // hit on the all-ones line
        send_item(ACT_ACCESS, 32'h0000_0020);     // neighbouring set
        send_item(ACT_ACCESS, 32'h0000_0100);     // same set, new tag, next way
        send_item(ACT_ACCESS, 32'h0000_0005);     // hit in way 0
        send_item(ACT_INVALIDATE, 32'h0000_0000); // clears lines and tick
        send_item(ACT_ACCESS, 32'h0000_0000);     // miss again after invalidate
        send_item(ACT_ACCESS, 32'hAAAA_AAAA);
        send_item(ACT_ACCESS, 32'h5555_5555);
        send_item(ACT_INVALIDATE, 32'hFFFF_FFFF); // address ignored
        send_item(ACT_INVALIDATE, 32'h1234_5678); // back-to-back invalidates
        send_item(ACT_ACCESS, 32'h8000_0000);
        send_item(ACT_ACCESS, 32'h7FFF_FFFF);
        send_item(ACT_ACCESS, 32'h8000_001F);     // hit, upper tag bit
        send_item(ACT_ACCESS, 32'h0000_00E0);     // set 7, offset 0
        send_item(ACT_ACCESS, 32'h0000_00E0);     // repeat hit
        drain_results();
    endtask

    // address from the phase pool, hot sets, random offset; now and then any address
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [SET_W-1:0] set_sel;
        if ($urandom_range(0, 15) == 0)
            return $urandom;
        set_sel = SET_W'((hot_set_base + $urandom_range(0, hot_set_span - 1)) % NUM_SETS);
        return {tag_pool[$urandom_range(0, pool_size - 1)], set_sel,
                OFFSET_W'($urandom_range(0, LINE_BYTES - 1))};
    endfunction

    task automatic run_random();
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            // first phase runs with no idling at all
            sender_idle_on   = (p == 0) ? 1'b0 : $urandom_range(0, 2) != 0;
            receiver_idle_on = (p == 0) ? 1'b0 : $urandom_range(0, 2) != 0;
            // pools above the way count force full sets and evictions
            pool_size    = $urandom_range(20, POOL_MAX);
            hot_set_base = $urandom_range(0, NUM_SETS - 1);
            hot_set_span = $urandom_range(1, 3);
            foreach (tag_pool[i])
                tag_pool[i] = TAG_HI_W'($urandom);
            if (p == 2)
            begin
                // receiver holds off while the sender keeps offering
                sender_idle_on = 1'b0;
                rx_hold_req    = LONG_HOLD;
            end
            if (p == 5 || p == 8)
                drain_results();
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 59) == 0)
                    send_item(ACT_INVALIDATE, $urandom);
                else
                    send_item(ACT_ACCESS, pick_address());
            end
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        s_tvalid         <= 1'b0;
        s_tdata          <= '0;
        s_tuser          <= ACT_ACCESS;
        cycle_count      = 0;
        rx_hold_req      = 0;
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        sb.clear_lines();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();

        // let the last results out, then a short settle
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
src/sacl_pkg.sv
src/sacl_ram.sv
src/sacl_lookup.sv
src/sacl_min_search.sv
src/set_assoc_cache_tag_lru_core.sv
tb/sv/set_assoc_cache_tag_lru_core_tb.sv
